// ===== sv/svcs_pkg.sv =====
`timescale 1ns / 1ps
package svcs_pkg;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  localparam int FieldW = 16;
  localparam int IdW    = 8;
  localparam int StampW = 32;

  typedef struct packed {
    mode_e             mode;
    logic [FieldW-1:0] pos_x;
    logic [FieldW-1:0] pos_y;
    logic [FieldW-1:0] pos_z;
    logic [IdW-1:0]    block_value;
  } req_t;

endpackage

// ===== sv/svcs_front.sv =====
`timescale 1ns / 1ps
module svcs_front #(
  parameter int QDEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  svcs_pkg::req_t      in_req_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output svcs_pkg::req_t      q_req_o
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  svcs_pkg::req_t  mem_q [QDEPTH];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q;
  logic            push;

  assign in_stall_o = (cnt_q == (PW+1)'(QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_req_o    = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (q_pop_i) begin
        rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_req_i;
    end
  end

endmodule

// ===== sv/svcs_back.sv =====
`timescale 1ns / 1ps
module svcs_back #(
  parameter int CHUNK_BITS = 4,
  parameter int MAX_CHUNKS = 8,
  parameter int ID_BITS    = 8,
  parameter int COORD_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_pop_o,
  input  svcs_pkg::req_t              q_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [svcs_pkg::IdW-1:0]    read_value_o,
  output logic [15:0]                 total_blocks_o,
  output logic signed [15:0]          bound_min_x_o,
  output logic signed [15:0]          bound_min_y_o,
  output logic signed [15:0]          bound_min_z_o,
  output logic signed [15:0]          bound_max_x_o,
  output logic signed [15:0]          bound_max_y_o,
  output logic signed [15:0]          bound_max_z_o,
  output logic                        table_full_o,
  output logic [svcs_pkg::StampW-1:0] chunk_stamp_o
);

  localparam int KB    = COORD_BITS - CHUNK_BITS;
  localparam int KEYW  = 3 * KB;
  localparam int LOCW  = 3 * CHUNK_BITS;
  localparam int VOL   = 1 << LOCW;
  localparam int SW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int AW    = SW + LOCW;
  localparam int DEPTH = MAX_CHUNKS * VOL;
  localparam int FCW   = LOCW + 1;
  localparam int StampWL = svcs_pkg::StampW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK, ST_RDWAIT, ST_RDMEM, ST_DECIDE, ST_CLR, ST_WR,
    ST_NB, ST_NBCHK, ST_RES, ST_OUT
  } state_e;

  state_e state_q;

  logic                  valid_q [MAX_CHUNKS];
  logic [KEYW-1:0]       key_q   [MAX_CHUNKS];
  logic [FCW-1:0]        fill_q  [MAX_CHUNKS];
  logic [StampWL-1:0]    stamp_q [MAX_CHUNKS];

  logic [ID_BITS-1:0]    vox_mem [DEPTH];
  logic [ID_BITS-1:0]    rd_q;

  logic [16:0]           total_q;
  logic signed [COORD_BITS-1:0] lo_q [3];
  logic signed [COORD_BITS-1:0] hi_q [3];
  logic [StampWL-1:0]    ctr_q;

  svcs_pkg::mode_e       mode_q;
  logic signed [COORD_BITS-1:0] p_q [3];
  logic [ID_BITS-1:0]    id_q;
  logic signed [KB-1:0]  ck_q [3];
  logic [LOCW-1:0]       loc_q;
  logic                  hit_q;
  logic [SW-1:0]         slot_q;
  logic                  full_q;
  logic [AW-1:0]         addr_q;
  logic [LOCW-1:0]       clr_q;
  logic [1:0]            d_q [3];

  logic [ID_BITS-1:0]    r_value_q;
  logic [15:0]           r_total_q;
  logic [StampWL-1:0]    r_stamp_q;
  logic                  r_full_q;
  logic                  out_valid_q;

  // Neighbour chunk search: chunk coordinate for current offset, range-checked.
  logic signed [KB+1:0]  nc [3];
  logic                  n_ok;
  logic [KEYW-1:0]       n_key;
  logic                  n_hit;
  logic [SW-1:0]         n_slot;
  logic [KEYW-1:0]       own_key;
  logic                  own_hit;
  logic [SW-1:0]         own_slot;
  logic                  free_ok;
  logic [SW-1:0]         free_slot;
  logic                  d_last;
  logic [COORD_BITS:0]   pe [3];
  logic signed [KB+1:0]  clo [3];
  logic signed [KB+1:0]  chi [3];

  always_comb begin
    n_ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      pe[a]  = {p_q[a][COORD_BITS-1], p_q[a]};
      clo[a] = (KB+2)'($signed(pe[a] - 1'b1) >>> CHUNK_BITS);
      chi[a] = (KB+2)'($signed(pe[a] + 1'b1) >>> CHUNK_BITS);
      nc[a]  = clo[a] + (KB+2)'(d_q[a]);
      if (nc[a] < -(KB+2)'(1 << (KB-1)) || nc[a] > (KB+2)'((1 << (KB-1)) - 1)) begin
        n_ok = 1'b0;
      end
    end
    n_key   = {nc[2][KB-1:0], nc[1][KB-1:0], nc[0][KB-1:0]};
    own_key = {ck_q[2], ck_q[1], ck_q[0]};
    n_hit = 1'b0; n_slot = '0; own_hit = 1'b0; own_slot = '0;
    free_ok = 1'b0; free_slot = '0;
    for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == n_key) begin
        n_hit = n_ok; n_slot = SW'(i);
      end
      if (valid_q[i] && key_q[i] == own_key) begin
        own_hit = 1'b1; own_slot = SW'(i);
      end
      if (!valid_q[i]) begin
        free_ok = 1'b1; free_slot = SW'(i);
      end
    end
    d_last = ((clo[0] + (KB+2)'(d_q[0])) == chi[0]) &&
             ((clo[1] + (KB+2)'(d_q[1])) == chi[1]) &&
             ((clo[2] + (KB+2)'(d_q[2])) == chi[2]);
  end

  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      ctr_q       <= '0;
      for (int i = 0; i < MAX_CHUNKS; i++) valid_q[i] <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        lo_q[a] <= '0;
        hi_q[a] <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            mode_q <= q_req_i.mode;
            p_q[0] <= COORD_BITS'(q_req_i.pos_x);
            p_q[1] <= COORD_BITS'(q_req_i.pos_y);
            p_q[2] <= COORD_BITS'(q_req_i.pos_z);
            id_q   <= ID_BITS'(q_req_i.block_value);
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          for (int a = 0; a < 3; a++) begin
            ck_q[a] <= p_q[a][COORD_BITS-1:CHUNK_BITS];
          end
          loc_q <= {p_q[2][CHUNK_BITS-1:0], p_q[1][CHUNK_BITS-1:0],
                    p_q[0][CHUNK_BITS-1:0]};
          full_q <= 1'b0;
          state_q <= ST_RDWAIT;
        end
        ST_RDWAIT: begin
          hit_q  <= own_hit;
          slot_q <= own_slot;
          addr_q <= {own_slot, loc_q};
          state_q <= ST_RDMEM;
        end
        ST_RDMEM: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          // rd_q now holds the memory word at addr_q.
          logic [ID_BITS-1:0] bef;
          bef = hit_q ? rd_q : '0;
          r_value_q <= bef;
          d_q[0] <= '0; d_q[1] <= '0; d_q[2] <= '0;
          state_q <= ST_RES;
          if (mode_q == svcs_pkg::MODE_CLEAR) begin
            for (int i = 0; i < MAX_CHUNKS; i++) valid_q[i] <= 1'b0;
            total_q <= '0;
            for (int a = 0; a < 3; a++) begin
              lo_q[a] <= '0;
              hi_q[a] <= '0;
            end
          end else if (mode_q == svcs_pkg::MODE_WRITE) begin
            if (id_q == '0) begin
              if (hit_q && bef != '0) begin
                vox_mem[addr_q] <= '0;
                fill_q[slot_q] <= fill_q[slot_q] - 1'b1;
                total_q <= total_q - 1'b1;
                if (fill_q[slot_q] == FCW'(1)) valid_q[slot_q] <= 1'b0;
                state_q <= ST_NB;
              end
            end else if (!hit_q) begin
              if (!free_ok) begin
                full_q <= 1'b1;
              end else begin
                valid_q[free_slot] <= 1'b1;
                key_q[free_slot]   <= own_key;
                fill_q[free_slot]  <= '0;
                stamp_q[free_slot] <= '0;
                slot_q  <= free_slot;
                hit_q   <= 1'b1;
                clr_q   <= '0;
                state_q <= ST_CLR;
              end
            end else if (bef != id_q) begin
              state_q <= ST_WR;
            end
          end
        end
        ST_CLR: begin
          vox_mem[{slot_q, clr_q}] <= '0;
          clr_q <= clr_q + 1'b1;
          if (clr_q == LOCW'(VOL - 1)) begin
            addr_q  <= {slot_q, loc_q};
            r_value_q <= '0;
            state_q <= ST_WR;
          end
        end
        ST_WR: begin
          if (r_value_q == '0) begin
            fill_q[slot_q] <= fill_q[slot_q] + 1'b1;
            for (int a = 0; a < 3; a++) begin
              if (total_q == '0) begin
                lo_q[a] <= p_q[a];
                hi_q[a] <= p_q[a];
              end else begin
                if (p_q[a] < lo_q[a]) lo_q[a] <= p_q[a];
                if (p_q[a] > hi_q[a]) hi_q[a] <= p_q[a];
              end
            end
            total_q <= total_q + 1'b1;
          end
          vox_mem[addr_q] <= id_q;
          state_q <= ST_NB;
        end
        ST_NB: begin
          state_q <= ST_NBCHK;
        end
        ST_NBCHK: begin
          if (n_hit) begin
            ctr_q <= ctr_q + 1'b1;
            stamp_q[n_slot] <= ctr_q + 1'b1;
          end
          if (d_last) begin
            state_q <= ST_RES;
          end else begin
            state_q <= ST_NB;
            if ((clo[0] + (KB+2)'(d_q[0])) != chi[0]) begin
              d_q[0] <= d_q[0] + 1'b1;
            end else begin
              d_q[0] <= '0;
              if ((clo[1] + (KB+2)'(d_q[1])) != chi[1]) begin
                d_q[1] <= d_q[1] + 1'b1;
              end else begin
                d_q[1] <= '0;
                d_q[2] <= d_q[2] + 1'b1;
              end
            end
          end
        end
        ST_RES: begin
          r_total_q <= (total_q > 17'd65535) ? 16'hFFFF : total_q[15:0];
          r_full_q  <= full_q;
          r_stamp_q <= own_hit ? stamp_q[own_slot] : '0;
          out_valid_q <= 1'b1;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= vox_mem[addr_q];
  end

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = svcs_pkg::IdW'(r_value_q);
  assign total_blocks_o = r_total_q;
  assign bound_min_x_o  = 16'(lo_q[0]);
  assign bound_min_y_o  = 16'(lo_q[1]);
  assign bound_min_z_o  = 16'(lo_q[2]);
  assign bound_max_x_o  = 16'(hi_q[0]);
  assign bound_max_y_o  = 16'(hi_q[1]);
  assign bound_max_z_o  = 16'(hi_q[2]);
  assign table_full_o   = r_full_q;
  assign chunk_stamp_o  = r_stamp_q;

endmodule

// ===== sv/sparse_voxel_chunk_store_top.sv =====
`timescale 1ns / 1ps
// Sparse voxel store with a small chunk table. A read or clear runs through
// the lookup, memory read, decide and result states; a write that changes a
// block also visits each neighbour chunk position (up to eight) in ST_NB and
// ST_NBCHK and passes ST_WR when it stores a non-air id, and allocating a chunk
// first zeroes each block of its memory in ST_CLR. A stalled result holds the
// back end. The single-port voxel memory and the sequential neighbour stamping
// set the pace. A two-entry request queue lets the input side keep accepting
// while a result waits.
module sparse_voxel_chunk_store_top #(
  parameter int CHUNK_BITS = 4,
  parameter int MAX_CHUNKS = 8,
  parameter int ID_BITS    = 8,
  parameter int COORD_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic [7:0]  block_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_value_o,
  output logic [15:0] total_blocks_o,
  output logic signed [15:0] bound_min_x_o,
  output logic signed [15:0] bound_min_y_o,
  output logic signed [15:0] bound_min_z_o,
  output logic signed [15:0] bound_max_x_o,
  output logic signed [15:0] bound_max_y_o,
  output logic signed [15:0] bound_max_z_o,
  output logic        table_full_o,
  output logic [31:0] chunk_stamp_o
);

  svcs_pkg::req_t in_req, q_req;
  logic           q_valid, q_pop;

  assign in_req.mode        = svcs_pkg::mode_e'(mode_i);
  assign in_req.pos_x       = pos_x_i;
  assign in_req.pos_y       = pos_y_i;
  assign in_req.pos_z       = pos_z_i;
  assign in_req.block_value = block_value_i;

  svcs_front #(.QDEPTH(2)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .in_req_i(in_req), .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req)
  );

  svcs_back #(
    .CHUNK_BITS(CHUNK_BITS), .MAX_CHUNKS(MAX_CHUNKS),
    .ID_BITS(ID_BITS), .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_req_i(q_req),
    .out_valid_o, .out_stall_i, .read_value_o, .total_blocks_o,
    .bound_min_x_o, .bound_min_y_o, .bound_min_z_o,
    .bound_max_x_o, .bound_max_y_o, .bound_max_z_o,
    .table_full_o, .chunk_stamp_o
  );

endmodule

// ===== sv/svcs_checker.sv =====
`timescale 1ns / 1ps
module svcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] total_blocks_o,
  input logic        table_full_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(total_blocks_o))
    else $error("stalled result changed");

  a_full_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> total_blocks_o != 16'd0)
    else $error("table full with empty store");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("results back to back");

endmodule

bind sparse_voxel_chunk_store_top svcs_checker u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .total_blocks_o,
  .table_full_o
);
